>>> hw/rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// Property checked through reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/atpg_pkg.sv
`default_nettype none

package atpg_pkg;

   localparam int COORD_W    = 12;
   localparam int FRAME_W    = 32;
   localparam int DIM_W      = 13;
   localparam int COLOUR_W   = 8;
   localparam int CSR_IDX_W  = 2;

   // cell and stripe geometry
   localparam int CELL_SHIFT = 5;
   localparam int CELL_W     = COORD_W - CELL_SHIFT;
   localparam int STRIPE_W   = 6;

   // frame_count / 5 by reciprocal; /10 is that quotient halved
   localparam logic [FRAME_W-1:0] RECIP_5 = 32'hCCCC_CCCD;
   localparam int RECIP_SHIFT = 34;
   localparam int Q5_W        = COLOUR_W + 1;

   localparam logic [COLOUR_W-1:0] CELL_STEP_RG = 8'd50;
   localparam logic [COLOUR_W-1:0] CELL_STEP_B  = 8'd30;
   localparam logic [COLOUR_W-1:0] LEVEL_WHITE  = 8'hFF;
   localparam logic [COLOUR_W-1:0] LEVEL_BLACK  = 8'h00;

   // gradient dividends: x*256, y*256 and (x+y)*128 are all this wide
   localparam int DVD_W = COORD_W + COLOUR_W;

   localparam int MAX_DIMENSION_DEF = 4096;
   localparam int QUEUE_DEPTH_DEF   = 4;
   localparam int WIDTH_RESET       = 800;
   localparam int HEIGHT_RESET      = 600;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_MODE = 2'd0,
      CSR_FRAME_WIDTH  = 2'd1,
      CSR_FRAME_HEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic                gradient;
      pixel_type           pixel;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [COLOUR_W-1:0] shift;
   } entry_type;

   typedef struct packed {
      logic             gradient;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } cfg_type;

endpackage

`default_nettype wire

>>> hw/rtl/atpg_front.sv
`default_nettype none

module atpg_front import atpg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [COORD_W-1:0] req_pixel_x,
   input  logic [COORD_W-1:0] req_pixel_y,
   input  logic [FRAME_W-1:0] req_frame_count,
   input  logic               gradient,
   input  logic               queue_full,
   output logic               queue_push,
   output entry_type          queue_entry
);

   logic                  a_vld_ff, a_vld_in;
   logic [COORD_W-1:0]    a_x_ff;
   logic [COORD_W-1:0]    a_y_ff;
   logic [COLOUR_W-1:0]   a_fc_ff;
   logic [Q5_W-1:0]       a_q5_ff;
   logic                  a_grad_ff;

   logic [2*FRAME_W-1:0]  prod;
   logic                  take;
   logic [CELL_W-1:0]     cx, cy;
   logic [CELL_W:0]       cell_sum;
   logic [COORD_W:0]      stripe_pos;
   logic                  even_cell;
   logic [COLOUR_W-1:0]   level;

   assign prod = {{FRAME_W{1'b0}}, req_frame_count} * {{FRAME_W{1'b0}}, RECIP_5};

   assign req_ready  = !a_vld_ff || !queue_full;
   assign take       = req_valid && req_ready;
   assign queue_push = a_vld_ff && !queue_full;

   always_comb begin
      a_vld_in = a_vld_ff;
      if (take) begin
         a_vld_in = 1'b1;
      end else if (queue_push) begin
         a_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         a_x_ff    <= req_pixel_x;
         a_y_ff    <= req_pixel_y;
         a_fc_ff   <= req_frame_count[COLOUR_W-1:0];
         a_q5_ff   <= prod[RECIP_SHIFT+Q5_W-1:RECIP_SHIFT];
         a_grad_ff <= gradient;
      end
   end

   // classify and build the checkerboard colour; gradient work is left to the back end
   always_comb begin
      cx         = a_x_ff[COORD_W-1:CELL_SHIFT];
      cy         = a_y_ff[COORD_W-1:CELL_SHIFT];
      cell_sum   = {1'b0, cx} + {1'b0, cy};
      even_cell  = (cx[0] == cy[0]);
      stripe_pos = {1'b0, a_x_ff} + (COORD_W+1)'(a_q5_ff[STRIPE_W-1:0]);
      level      = stripe_pos[CELL_SHIFT] ? LEVEL_WHITE : LEVEL_BLACK;

      queue_entry.gradient = a_grad_ff;
      queue_entry.x        = a_x_ff;
      queue_entry.y        = a_y_ff;
      queue_entry.shift    = a_q5_ff[Q5_W-1:1];
      if (even_cell) begin
         queue_entry.pixel.red   = COLOUR_W'(cx * CELL_STEP_RG) + a_fc_ff;
         queue_entry.pixel.green = COLOUR_W'(cy * CELL_STEP_RG) + a_fc_ff;
         queue_entry.pixel.blue  = COLOUR_W'(cell_sum * CELL_STEP_B) + a_fc_ff;
      end else begin
         queue_entry.pixel.red   = level;
         queue_entry.pixel.green = level;
         queue_entry.pixel.blue  = level;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/atpg_queue.sv
`default_nettype none

module atpg_queue import atpg_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type entry_in,
   output logic      full,
   input  logic      pop,
   output entry_type entry_out,
   output logic      empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   entry_type         slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign entry_out = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/atpg_div_lane.sv
`default_nettype none

// Restoring divider, one quotient bit per stage; keeps the low QUO_W bits of the quotient.
module atpg_div_lane import atpg_pkg::*; #(
   parameter int NUM_W = DVD_W,
   parameter int DEN_W = DIM_W,
   parameter int QUO_W = COLOUR_W
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic [QUO_W-1:0] quotient
);

   localparam int STAGES = NUM_W;

   logic [DEN_W-1:0] rem_ff [STAGES];
   logic [NUM_W-1:0] num_ff [STAGES];
   logic [QUO_W-1:0] quo_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [DEN_W-1:0] rem_prev, rem_in;
      logic [NUM_W-1:0] num_prev, num_in;
      logic [QUO_W-1:0] quo_prev, quo_in;
      logic [DEN_W:0]   trial, diff;
      logic             fits;

      if (s == 0) begin : g_first
         assign rem_prev = '0;
         assign num_prev = dividend;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign num_prev = num_ff[s-1];
         assign quo_prev = quo_ff[s-1];
      end

      // remainder stays below the divisor, so the trial fits in DEN_W+1 bits
      assign trial  = {rem_prev, num_prev[NUM_W-1]};
      assign diff   = trial - {1'b0, divisor};
      assign fits   = (trial >= {1'b0, divisor});
      assign rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      assign num_in = {num_prev[NUM_W-2:0], 1'b0};
      assign quo_in = {quo_prev[QUO_W-2:0], fits};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s] <= rem_in;
            num_ff[s] <= num_in;
            quo_ff[s] <= quo_in;
         end
      end
   end

   assign quotient = quo_ff[STAGES-1];

endmodule

`default_nettype wire

>>> hw/rtl/atpg_back.sv
`default_nettype none

module atpg_back import atpg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                queue_empty,
   input  entry_type           queue_entry,
   output logic                queue_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COLOUR_W-1:0] rsp_red,
   output logic [COLOUR_W-1:0] rsp_green,
   output logic [COLOUR_W-1:0] rsp_blue
);

   localparam int STAGES = DVD_W;

   typedef struct packed {
      logic                gradient;
      pixel_type           pixel;
      logic [COLOUR_W-1:0] shift;
   } side_type;

   logic                vld_ff  [STAGES];
   side_type            side_ff [STAGES];
   logic                out_vld_ff;
   pixel_type           out_pix_ff, out_pix_in;
   logic                adv;
   logic [COORD_W:0]    xy_sum;
   logic [DIM_W:0]      wh_sum;
   logic [COLOUR_W-1:0] quo_red, quo_green, quo_blue;
   side_type            side_last;

   assign adv       = !out_vld_ff || rsp_ready;
   assign queue_pop = adv && !queue_empty;

   assign xy_sum = {1'b0, queue_entry.x} + {1'b0, queue_entry.y};
   assign wh_sum = {1'b0, cfg.width} + {1'b0, cfg.height};

   atpg_div_lane #(.NUM_W(DVD_W), .DEN_W(DIM_W), .QUO_W(COLOUR_W)) u_div_red (
      .clock    (clock),
      .enable   (adv),
      .dividend ({queue_entry.x, {COLOUR_W{1'b0}}}),
      .divisor  (cfg.width),
      .quotient (quo_red)
   );

   atpg_div_lane #(.NUM_W(DVD_W), .DEN_W(DIM_W), .QUO_W(COLOUR_W)) u_div_green (
      .clock    (clock),
      .enable   (adv),
      .dividend ({queue_entry.y, {COLOUR_W{1'b0}}}),
      .divisor  (cfg.height),
      .quotient (quo_green)
   );

   atpg_div_lane #(.NUM_W(DVD_W), .DEN_W(DIM_W+1), .QUO_W(COLOUR_W)) u_div_blue (
      .clock    (clock),
      .enable   (adv),
      .dividend ({xy_sum, {(COLOUR_W-1){1'b0}}}),
      .divisor  (wh_sum),
      .quotient (quo_blue)
   );

   // side line runs alongside the divider stages
   for (genvar s = 0; s < STAGES; s++) begin : g_side
      logic     vld_prev;
      side_type side_prev;

      if (s == 0) begin : g_first
         assign vld_prev  = !queue_empty;
         assign side_prev = '{gradient: queue_entry.gradient,
                              pixel:    queue_entry.pixel,
                              shift:    queue_entry.shift};
      end else begin : g_next
         assign vld_prev  = vld_ff[s-1];
         assign side_prev = side_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[s] <= side_prev;
         end
      end
   end

   assign side_last = side_ff[STAGES-1];

   always_comb begin
      if (side_last.gradient) begin
         out_pix_in.red   = quo_red + side_last.shift;
         out_pix_in.green = quo_green + side_last.shift;
         out_pix_in.blue  = quo_blue + side_last.shift;
      end else begin
         out_pix_in = side_last.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_pix_ff <= out_pix_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_red   = out_pix_ff.red;
   assign rsp_green = out_pix_ff.green;
   assign rsp_blue  = out_pix_ff.blue;

endmodule

`default_nettype wire

>>> hw/rtl/animated_test_pattern_generator_core.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_pixel_x, req_pixel_y, req_frame_count
// rsp       out        rsp_valid/rsp_ready    rsp_red, rsp_green, rsp_blue
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// One request per cycle sustained while rsp_ready is high, one result per request, in order.
// The path runs through one front stage, the queue, 20 divider stages
// (one quotient bit per stage for the gradient) and the output register.
// Synchronous active-high reset clears all valids and loads the register defaults.
// rsp_ready low with a result waiting freezes the back end; the request queue lets the front keep taking
// requests until it fills. csr_ready is always high.
`default_nettype none

module animated_test_pattern_generator_core import atpg_pkg::*; #(
   parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [COORD_W-1:0]   req_pixel_x,
   input  logic [COORD_W-1:0]   req_pixel_y,
   input  logic [FRAME_W-1:0]   req_frame_count,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [COLOUR_W-1:0]  rsp_red,
   output logic [COLOUR_W-1:0]  rsp_green,
   output logic [COLOUR_W-1:0]  rsp_blue,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data
);

   localparam int W_RST = (WIDTH_RESET > MAX_DIMENSION) ? MAX_DIMENSION : WIDTH_RESET;
   localparam int H_RST = (HEIGHT_RESET > MAX_DIMENSION) ? MAX_DIMENSION : HEIGHT_RESET;

   cfg_type          cfg_ff, cfg_in;
   logic [DIM_W-1:0] dim_clamped;
   logic             csr_write;

   logic             queue_full, queue_push, queue_pop, queue_empty;
   entry_type        push_entry, pop_entry;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // frame size is held already limited to 1..MAX_DIMENSION
   always_comb begin
      dim_clamped = csr_data;
      if (csr_data == '0) begin
         dim_clamped = DIM_W'(1);
      end else if (32'(csr_data) > MAX_DIMENSION) begin
         dim_clamped = DIM_W'(MAX_DIMENSION);
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_MODE: cfg_in.gradient = csr_data[0];
            CSR_FRAME_WIDTH:  cfg_in.width    = dim_clamped;
            CSR_FRAME_HEIGHT: cfg_in.height   = dim_clamped;
            default:          cfg_in          = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gradient <= 1'b0;
         cfg_ff.width    <= DIM_W'(W_RST);
         cfg_ff.height   <= DIM_W'(H_RST);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   atpg_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_frame_count (req_frame_count),
      .gradient        (cfg_ff.gradient),
      .queue_full      (queue_full),
      .queue_push      (queue_push),
      .queue_entry     (push_entry)
   );

   atpg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .entry_in  (push_entry),
      .full      (queue_full),
      .pop       (queue_pop),
      .entry_out (pop_entry),
      .empty     (queue_empty)
   );

   atpg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .queue_entry (pop_entry),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_red     (rsp_red),
      .rsp_green   (rsp_green),
      .rsp_blue    (rsp_blue)
   );

endmodule

`default_nettype wire

>>> hw/rtl/atpg_checker.sv
`default_nettype none

`include "assert_macros.svh"

module atpg_checker import atpg_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [COLOUR_W-1:0]  rsp_red,
   input logic [COLOUR_W-1:0]  rsp_green,
   input logic [COLOUR_W-1:0]  rsp_blue,
   input logic                 csr_ready
);

   // a stalled pixel holds until taken
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue), "rsp changed while stalled")

   // register writes are never back-pressured
   `ASSERT_NEVER(a_csr_ready, clock, reset, !csr_ready, "csr_ready dropped")

   // reset empties the pipe and frees the front stage
   `ASSERT_ALWAYS(a_rst_rsp, clock, reset |=> !rsp_valid, "rsp_valid after reset")
   `ASSERT_ALWAYS(a_rst_req, clock, reset |=> req_ready, "req_ready low after reset")

endmodule

bind animated_test_pattern_generator_core atpg_checker u_atpg_checker (.*);

`default_nettype wire
